// ===== design/eeprom_tlv_record_parser_defines.svh =====
// shared assertion macros for the record parser
`ifndef EEPROM_TLV_RECORD_PARSER_DEFINES_SVH
`define EEPROM_TLV_RECORD_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define EETLV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define EETLV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/eetlv_pkg.sv =====
package eetlv_pkg;

    // parser phases
    localparam logic [2:0] PH_M0   = 3'd0;
    localparam logic [2:0] PH_M1   = 3'd1;
    localparam logic [2:0] PH_M2   = 3'd2;
    localparam logic [2:0] PH_CODE = 3'd3;
    localparam logic [2:0] PH_LEN  = 3'd4;
    localparam logic [2:0] PH_PAY  = 3'd5;
    localparam logic [2:0] PH_DONE = 3'd6;

    // result kinds
    localparam logic [2:0] K_TEXT = 3'd0;
    localparam logic [2:0] K_MAC  = 3'd1;
    localparam logic [2:0] K_DATE = 3'd2;
    localparam logic [2:0] K_WORD = 3'd3;
    localparam logic [2:0] K_CRC  = 3'd4;
    localparam logic [2:0] K_BAD  = 3'd5;
    localparam logic [2:0] K_END  = 3'd6;

    // image magic
    localparam logic [7:0] MAGIC_0 = 8'hFF;
    localparam logic [7:0] MAGIC_1 = 8'h01;
    localparam logic [7:0] MAGIC_2 = 8'hE0;

    // record codes
    localparam logic [7:0] CODE_CRC    = 8'h00;
    localparam logic [7:0] CODE_TEXT_1 = 8'h01;
    localparam logic [7:0] CODE_TEXT_2 = 8'h02;
    localparam logic [7:0] CODE_TEXT_3 = 8'h03;
    localparam logic [7:0] CODE_MAC    = 8'h04;
    localparam logic [7:0] CODE_DATE   = 8'h05;
    localparam logic [7:0] CODE_WORD_6 = 8'h06;
    localparam logic [7:0] CODE_WORD_7 = 8'h07;
    localparam logic [7:0] CODE_TEXT_8 = 8'h08;
    localparam logic [7:0] CODE_TEXT_9 = 8'h09;
    localparam logic [7:0] CODE_WORD_A = 8'h0A;

    // payload limits
    localparam logic [7:0] MAC_BYTES     = 8'd6;
    localparam logic [7:0] DATE_BYTES    = 8'd4;
    localparam logic [7:0] WORD_LAST_POS = 8'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  record_code;
        logic [7:0]  byte_offset;
        logic [31:0] value;
        logic        final_res;
    } t_result;

endpackage

// ===== design/eeprom_tlv_record_parser.sv =====
// Board-information EEPROM record parser. Takes the image one byte per beat, checks the
// magic FF 01 E0 and then walks code/length/payload records, giving at most one result
// beat per input byte: tagged text, MAC and date bytes, a 32-bit big-endian word for codes
// 6, 7 and 10, the 16-bit CRC (which ends parsing), bad magic and end-of-image. An input
// beat is taken every cycle while the skid register is empty; all per-byte work is one
// combinational pass from the state registers into the output register. A skid register
// behind the output register absorbs one result while the sink stalls, and o_stall
// rises only while that skid register is full. i_image_end rearms the parser.
`include "eeprom_tlv_record_parser_defines.svh"

module eeprom_tlv_record_parser
    import eetlv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_image_byte,
    input  logic        i_image_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_record_code,
    output logic [7:0]  o_byte_offset,
    output logic [31:0] o_value,
    output logic        o_final_res
);

    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_code, n_code;
    logic [7:0]  r_left, n_left;
    logic [7:0]  r_pos, n_pos;
    logic [23:0] r_accum, n_accum;

    logic        r_out_valid, n_out_valid;
    logic        r_skd_valid, n_skd_valid;
    t_result     r_out, r_skd;

    t_result     res;
    logic        res_valid;
    logic        res_fin;
    logic        in_acc;
    logic        out_take;
    logic        load_out_res;
    logic        load_out_skd;
    logic        load_skd;
    logic [7:0]  magic_exp;
    logic [7:0]  left_dec;

    assign in_acc   = i_valid && !r_skd_valid;
    assign out_take = r_out_valid && !i_stall;
    assign left_dec = r_left - 8'd1;

    always_comb begin
        unique case (r_phase)
            PH_M0:   magic_exp = MAGIC_0;
            PH_M1:   magic_exp = MAGIC_1;
            default: magic_exp = MAGIC_2;
        endcase
    end

    // per-byte parse step
    always_comb begin
        n_phase   = r_phase;
        n_code    = r_code;
        n_left    = r_left;
        n_pos     = r_pos;
        n_accum   = r_accum;
        res       = '0;
        res_valid = 1'b0;
        res_fin   = 1'b0;

        unique case (r_phase)
            PH_M0, PH_M1, PH_M2: begin
                if (i_image_byte != magic_exp) begin
                    res.kind      = K_BAD;
                    res.final_res = 1'b1;
                    res_valid     = 1'b1;
                    res_fin       = 1'b1;
                    n_phase       = PH_DONE;
                end else if (i_image_end && r_phase != PH_M2) begin
                    res.kind      = K_BAD;
                    res.final_res = 1'b1;
                    res_valid     = 1'b1;
                    res_fin       = 1'b1;
                end else begin
                    n_phase = r_phase + 3'd1;
                end
            end
            PH_CODE: begin
                n_code  = i_image_byte;
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                if (i_image_byte == 8'd0) begin
                    res.kind        = K_END;
                    res.record_code = r_code;
                    res.final_res   = 1'b1;
                    res_valid       = 1'b1;
                    res_fin         = 1'b1;
                    n_phase         = PH_DONE;
                end else begin
                    n_left  = i_image_byte;
                    n_pos   = 8'd0;
                    n_accum = '0;
                    n_phase = PH_PAY;
                end
            end
            PH_PAY: begin
                res.record_code = r_code;
                res.byte_offset = r_pos;
                res.value       = {24'd0, i_image_byte};
                unique case (r_code)
                    CODE_TEXT_1, CODE_TEXT_2, CODE_TEXT_3, CODE_TEXT_8, CODE_TEXT_9: begin
                        res.kind  = K_TEXT;
                        res_valid = 1'b1;
                    end
                    CODE_MAC: begin
                        res.kind  = K_MAC;
                        res_valid = (r_pos < MAC_BYTES);
                    end
                    CODE_DATE: begin
                        res.kind  = K_DATE;
                        res_valid = (r_pos < DATE_BYTES);
                    end
                    CODE_WORD_6, CODE_WORD_7, CODE_WORD_A: begin
                        res.kind  = K_WORD;
                        res.value = {r_accum, i_image_byte};
                        if (r_pos < WORD_LAST_POS) begin
                            n_accum = {r_accum[15:0], i_image_byte};
                        end else if (r_pos == WORD_LAST_POS) begin
                            res_valid = 1'b1;
                        end
                    end
                    CODE_CRC: begin
                        res.kind      = K_CRC;
                        res.final_res = 1'b1;
                        if (r_pos == 8'd0 && r_left > 8'd1) begin
                            n_accum = {16'd0, i_image_byte};
                        end else if (r_pos == 8'd0) begin
                            res.value = {16'd0, i_image_byte, 8'd0};
                            res_valid = 1'b1;
                            res_fin   = 1'b1;
                        end else begin
                            res.value = {16'd0, r_accum[7:0], i_image_byte};
                            res_valid = 1'b1;
                            res_fin   = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (res_fin) begin
                    n_phase = PH_DONE;
                end else begin
                    n_left = left_dec;
                    n_pos  = r_pos + 8'd1;
                    if (left_dec == 8'd0) begin
                        n_phase = PH_CODE;
                    end
                end
            end
            default: begin
                res_fin = 1'b1;
            end
        endcase

        if (i_image_end) begin
            if (res_valid) begin
                res.final_res = 1'b1;
            end else if (!res_fin) begin
                res             = '0;
                res.kind        = K_END;
                res.record_code = n_code;
                res.final_res   = 1'b1;
                res_valid       = 1'b1;
            end
            n_phase = PH_M0;
            n_code  = '0;
            n_left  = '0;
            n_pos   = '0;
            n_accum = '0;
        end
    end

    // output register with skid stage
    always_comb begin
        load_out_res = 1'b0;
        load_out_skd = 1'b0;
        load_skd     = 1'b0;
        n_out_valid  = r_out_valid;
        n_skd_valid  = r_skd_valid;
        if (!r_out_valid || out_take) begin
            if (r_skd_valid) begin
                load_out_skd = 1'b1;
                n_out_valid  = 1'b1;
                n_skd_valid  = 1'b0;
            end else begin
                load_out_res = in_acc && res_valid;
                n_out_valid  = in_acc && res_valid;
            end
        end else if (in_acc && res_valid) begin
            load_skd    = 1'b1;
            n_skd_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_M0;
            r_code      <= '0;
            r_left      <= '0;
            r_pos       <= '0;
            r_accum     <= '0;
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase <= n_phase;
                r_code  <= n_code;
                r_left  <= n_left;
                r_pos   <= n_pos;
                r_accum <= n_accum;
            end
            r_out_valid <= n_out_valid;
            r_skd_valid <= n_skd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out_skd) begin
            r_out <= r_skd;
        end else if (load_out_res) begin
            r_out <= res;
        end
        if (load_skd) begin
            r_skd <= res;
        end
    end

    assign o_stall       = r_skd_valid;
    assign o_valid       = r_out_valid;
    assign o_kind        = r_out.kind;
    assign o_record_code = r_out.record_code;
    assign o_byte_offset = r_out.byte_offset;
    assign o_value       = r_out.value;
    assign o_final_res   = r_out.final_res;

    `EETLV_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skd_valid, r_out_valid, "skid full while output register empty")
    `EETLV_ASSERT_NEXT(a_end_rearms, i_clk, i_rst_n, in_acc && i_image_end, r_phase == PH_M0, "image end did not rearm parser")
    `EETLV_ASSERT_NOW(a_done_silent, i_clk, i_rst_n, in_acc && r_phase == PH_DONE, !res_valid, "result produced after parsing stopped")

endmodule
